@@ hdl/ffba_pkg.sv @@
// Shared types, widths and codes for the first-fit block allocator.
package ffba_pkg;

   // Buffer and table dimensions
   localparam int BUFFER_BYTES = 1024;
   localparam int MAX_BLOCKS   = 16;

   localparam int OFFSET_W = $clog2(BUFFER_BYTES);
   localparam int SIZE_W   = OFFSET_W + 1;
   localparam int SUM_W    = SIZE_W + 1;
   localparam int IDX_W    = $clog2(MAX_BLOCKS);
   localparam int COUNT_W  = $clog2(MAX_BLOCKS + 1);

   // Request operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_TABLE_FULL = 2'd2,
      ST_NOT_ALLOC = 2'd3
   } status_type;

   typedef struct packed {
      logic                func;
      logic [SIZE_W-1:0]   alloc_size;
      logic [OFFSET_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] result_offset;
      status_type          status;
      logic [COUNT_W-1:0]  blocks_in_use;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       scan_init;
      logic       set_slot;
      logic       advance_pos;
      logic       step_next;
      logic       step_prev;
      logic       shift_init;
      logic       write_up;
      logic       write_dn;
      logic       write_new;
      logic       finish;
      logic       count_inc;
      logic       count_dec;
      status_type status;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_alloc;
      logic table_full;
      logic size_bad;
      logic count_zero;
      logic fits_before;
      logic pos_fit;
      logic start_match;
      logic idx_last;
      logic idx_at_slot;
      logic slot_at_end;
   } dp_stat_type;

endpackage

@@ hdl/ffba_dp.sv @@
// Datapath: block table memory, scan position, counters and result register.
module ffba_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  ffba_pkg::req_type     req_data,
   input  ffba_pkg::ctrl_cmd_type cmd,
   output ffba_pkg::dp_stat_type stat,
   output ffba_pkg::rsp_type     rsp_data
);

   localparam int OFFSET_W = ffba_pkg::OFFSET_W;
   localparam int SIZE_W   = ffba_pkg::SIZE_W;
   localparam int SUM_W    = ffba_pkg::SUM_W;
   localparam int IDX_W    = ffba_pkg::IDX_W;
   localparam int COUNT_W  = ffba_pkg::COUNT_W;

   // Block table, sorted by start
   logic [OFFSET_W-1:0] entry_start_ff  [ffba_pkg::MAX_BLOCKS];
   logic [SIZE_W-1:0]   entry_length_ff [ffba_pkg::MAX_BLOCKS];

   ffba_pkg::req_type   req_ff;
   logic [OFFSET_W-1:0] rd_start_ff;
   logic [SIZE_W-1:0]   rd_length_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [SIZE_W-1:0]   pos_ff, pos_in;
   logic [COUNT_W-1:0]  slot_ff, slot_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   ffba_pkg::rsp_type   rsp_ff, rsp_in;

   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    wr_addr;
   logic                wr_en;
   logic [OFFSET_W-1:0] wr_start;
   logic [SIZE_W-1:0]   wr_length;
   logic [SUM_W-1:0]    pos_end;
   logic [SIZE_W-1:0]   rd_end;
   logic [COUNT_W-1:0]  idx_next_count;

   // Compare the candidate gap against the entry just read
   always_comb begin
      pos_end        = SUM_W'(pos_ff) + SUM_W'(req_ff.alloc_size);
      rd_end         = SIZE_W'(rd_start_ff) + rd_length_ff;
      idx_next_count = COUNT_W'(idx_ff) + COUNT_W'(1);

      stat.is_alloc    = (req_ff.func == ffba_pkg::FUNC_ALLOC);
      stat.table_full  = (count_ff == COUNT_W'(ffba_pkg::MAX_BLOCKS));
      stat.size_bad    = (req_ff.alloc_size == '0) ||
                         (req_ff.alloc_size > SIZE_W'(ffba_pkg::BUFFER_BYTES));
      stat.count_zero  = (count_ff == '0);
      stat.fits_before = (pos_end <= SUM_W'(rd_start_ff));
      stat.pos_fit     = (pos_end <= SUM_W'(ffba_pkg::BUFFER_BYTES));
      stat.start_match = (rd_start_ff == req_ff.block_offset);
      stat.idx_last    = (idx_next_count == count_ff);
      stat.idx_at_slot = (COUNT_W'(idx_ff) == slot_ff);
      stat.slot_at_end = (slot_ff == count_ff);
   end

   // Select read address for next cycle
   always_comb begin
      if (cmd.scan_init) begin
         rd_addr = '0;
      end else if (cmd.step_next) begin
         rd_addr = idx_ff + IDX_W'(1);
      end else if (cmd.step_prev) begin
         rd_addr = idx_ff - IDX_W'(1);
      end else if (cmd.shift_init) begin
         rd_addr = IDX_W'(count_ff - COUNT_W'(1));
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Select write port: shift up, shift down, or new entry
   always_comb begin
      wr_en     = cmd.write_up | cmd.write_dn | cmd.write_new;
      wr_start  = rd_start_ff;
      wr_length = rd_length_ff;
      if (cmd.write_new) begin
         wr_addr   = IDX_W'(slot_ff);
         wr_start  = pos_ff[OFFSET_W-1:0];
         wr_length = req_ff.alloc_size;
      end else if (cmd.write_up) begin
         wr_addr = idx_ff + IDX_W'(1);
      end else begin
         wr_addr = idx_ff - IDX_W'(1);
      end
   end

   // Next index, position, slot, count and result
   always_comb begin
      idx_in   = rd_addr;
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      rsp_in   = rsp_ff;

      if (cmd.scan_init) begin
         pos_in  = '0;
         slot_in = count_ff;
      end
      if (cmd.advance_pos) begin
         pos_in = rd_end;
      end
      if (cmd.set_slot) begin
         slot_in = COUNT_W'(idx_ff);
      end
      if (cmd.count_inc) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - COUNT_W'(1);
      end

      if (cmd.finish) begin
         rsp_in.status        = cmd.status;
         rsp_in.blocks_in_use = count_in;
         if (!stat.is_alloc) begin
            rsp_in.result_offset = req_ff.block_offset;
         end else if (cmd.status == ffba_pkg::ST_OK) begin
            rsp_in.result_offset = pos_ff[OFFSET_W-1:0];
         end else begin
            rsp_in.result_offset = '0;
         end
      end
   end

   // Table memory: at most one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_start_ff[wr_addr]  <= wr_start;
         entry_length_ff[wr_addr] <= wr_length;
      end
      rd_start_ff  <= entry_start_ff[rd_addr];
      rd_length_ff <= entry_length_ff[rd_addr];
   end

   // Hold payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      slot_ff <= slot_in;
      rsp_ff  <= rsp_in;
   end

   // Block count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ffba_pkg::MAX_BLOCKS))
      else $error("block count above table depth");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.count_inc |-> count_ff < COUNT_W'(ffba_pkg::MAX_BLOCKS))
      else $error("insert into full table");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_up || cmd.write_dn) |-> COUNT_W'(idx_ff) < count_ff)
      else $error("shift touches entry beyond count");

endmodule

@@ hdl/ffba_ctrl.sv @@
// Controller: sequences scan, shift and insert steps for each request.
module ffba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ffba_pkg::dp_stat_type  stat,
   output ffba_pkg::ctrl_cmd_type cmd,
   output logic                   rsp_strobe
);

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_DECIDE    = 8'b0000_0010,
      S_SCAN      = 8'b0000_0100,
      S_FIT       = 8'b0000_1000,
      S_SHIFT_UP  = 8'b0001_0000,
      S_WRITE_NEW = 8'b0010_0000,
      S_FIND      = 8'b0100_0000,
      S_SHIFT_DN  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff;

   assign busy = (state_ff != S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ffba_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_alloc) begin
               if (stat.table_full) begin
                  cmd.finish = 1'b1;
                  cmd.status = ffba_pkg::ST_TABLE_FULL;
                  state_in   = S_IDLE;
               end else if (stat.size_bad) begin
                  cmd.finish = 1'b1;
                  cmd.status = ffba_pkg::ST_NO_SPACE;
                  state_in   = S_IDLE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = stat.count_zero ? S_FIT : S_SCAN;
               end
            end else if (stat.count_zero) begin
               cmd.finish = 1'b1;
               cmd.status = ffba_pkg::ST_NOT_ALLOC;
               state_in   = S_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_FIND;
            end
         end
         S_SCAN: begin
            // Stop at first gap that holds the request, else move past this block
            if (stat.fits_before) begin
               cmd.set_slot = 1'b1;
               state_in     = S_FIT;
            end else begin
               cmd.advance_pos = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_FIT;
               end else begin
                  cmd.step_next = 1'b1;
               end
            end
         end
         S_FIT: begin
            if (!stat.pos_fit) begin
               cmd.finish = 1'b1;
               cmd.status = ffba_pkg::ST_NO_SPACE;
               state_in   = S_IDLE;
            end else if (stat.slot_at_end) begin
               state_in = S_WRITE_NEW;
            end else begin
               cmd.shift_init = 1'b1;
               state_in       = S_SHIFT_UP;
            end
         end
         S_SHIFT_UP: begin
            cmd.write_up = 1'b1;
            if (stat.idx_at_slot) begin
               state_in = S_WRITE_NEW;
            end else begin
               cmd.step_prev = 1'b1;
            end
         end
         S_WRITE_NEW: begin
            cmd.write_new = 1'b1;
            cmd.count_inc = 1'b1;
            cmd.finish    = 1'b1;
            state_in      = S_IDLE;
         end
         S_FIND: begin
            if (stat.start_match) begin
               if (stat.idx_last) begin
                  cmd.count_dec = 1'b1;
                  cmd.finish    = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.step_next = 1'b1;
                  state_in      = S_SHIFT_DN;
               end
            end else if (stat.idx_last) begin
               cmd.finish = 1'b1;
               cmd.status = ffba_pkg::ST_NOT_ALLOC;
               state_in   = S_IDLE;
            end else begin
               cmd.step_next = 1'b1;
            end
         end
         S_SHIFT_DN: begin
            // Pull each later entry down by one
            cmd.write_dn = 1'b1;
            if (stat.idx_last) begin
               cmd.count_dec = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.step_next = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == S_IDLE)
      else $error("result beat while request still in progress");

   a_load_decides: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DECIDE)
      else $error("accepted request did not reach decision");

   a_one_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !cmd.finish)
      else $error("two result beats in a row");

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// First-fit block allocator: start/busy command port, strobed result, one beat per request.
//
// A request is taken when start is high and busy is low; busy stays high until the
// result is known, and the result beat appears on rsp_data with rsp_strobe high for one
// cycle, the first cycle in which busy is low. The receiver cannot stall it. The block table
// is a memory with one write port and one registered read port, read one entry per cycle,
// so timing follows the table walk. An allocate walks the table to the first gap that fits
// (answering no space if none is left), shifts the later blocks up to make room and writes
// the new entry; a free walks the table to the matching block and moves the later blocks
// down; a full table, a bad size or a free on an empty table is answered from the decision
// state with no table walk. The next request may be started in the cycle the result strobe
// is shown. No clearing pass is needed after reset.
module first_fit_block_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ffba_pkg::rsp_type rsp_data
);

   ffba_pkg::ctrl_cmd_type cmd;
   ffba_pkg::dp_stat_type  stat;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .stat       (stat),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   ffba_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the first-fit block allocator: directed and random requests.
`timescale 1ns / 100ps

module tb_top;

   localparam int OFFSET_W     = ffba_pkg::OFFSET_W;
   localparam int SIZE_W       = ffba_pkg::SIZE_W;
   localparam int COUNT_W      = ffba_pkg::COUNT_W;
   localparam int BUFFER_BYTES = ffba_pkg::BUFFER_BYTES;
   localparam int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS;

   // Cycles with no beat in either direction before the run is abandoned.
   // Sender gaps are short random runs.
   localparam int QUIET_LIMIT     = 3000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int SETTLE_CYCLES   = 40;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              start      = 1'b0;
   ffba_pkg::req_type req_data   = '0;
   logic              busy;
   logic              rsp_strobe;
   ffba_pkg::rsp_type rsp_data;

   // Requests waiting to be presented and replies waiting to be seen
   ffba_pkg::req_type request_backlog[$];
   ffba_pkg::rsp_type expected_replies[$];

   // Shadow block table
   logic [OFFSET_W-1:0] used_start  [MAX_BLOCKS];
   logic [SIZE_W-1:0]   used_length [MAX_BLOCKS];
   int                  used_count = 0;

   int sender_idle_pct = 0;
   int failures        = 0;
   int quiet_cycles    = 0;
   int idle_plan [4]   = '{0, 69, 0, 18};

   first_fit_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #1 clock = ~clock;

   // Apply one request to the shadow table and return the reply it earns
   function automatic ffba_pkg::rsp_type apply_request(ffba_pkg::req_type r);
      ffba_pkg::rsp_type o;
      int                pos;
      int                slot;
      int                idx;
      logic              found;
      o = '0;
      o.status = ffba_pkg::ST_OK;
      pos = 0;
      slot = 0;
      found = 1'b0;
      if (r.func == ffba_pkg::FUNC_ALLOC) begin
         if (used_count >= MAX_BLOCKS) begin
            o.status = ffba_pkg::ST_TABLE_FULL;
         end else if (r.alloc_size == 0 || int'(r.alloc_size) > BUFFER_BYTES) begin
            o.status = ffba_pkg::ST_NO_SPACE;
         end else begin
            // walk gaps in start order, stop at the first block we fit in front of
            while (!found && slot < used_count) begin
               if (pos + int'(r.alloc_size) <= int'(used_start[slot])) begin
                  found = 1'b1;
               end else begin
                  pos = int'(used_start[slot]) + int'(used_length[slot]);
                  slot++;
               end
            end
            if (pos + int'(r.alloc_size) > BUFFER_BYTES) begin
               o.status = ffba_pkg::ST_NO_SPACE;
            end else begin
               // open a hole at slot and insert
               for (idx = used_count; idx > slot; idx--) begin
                  used_start[idx]  = used_start[idx-1];
                  used_length[idx] = used_length[idx-1];
               end
               used_start[slot]  = OFFSET_W'(pos);
               used_length[slot] = r.alloc_size;
               used_count++;
               o.result_offset = OFFSET_W'(pos);
            end
         end
      end else begin
         o.result_offset = r.block_offset;
         while (!found && slot < used_count) begin
            if (used_start[slot] == r.block_offset) found = 1'b1;
            else slot++;
         end
         if (!found) begin
            o.status = ffba_pkg::ST_NOT_ALLOC;
         end else begin
            // close the hole left by the freed block
            for (idx = slot; idx + 1 < used_count; idx++) begin
               used_start[idx]  = used_start[idx+1];
               used_length[idx] = used_length[idx+1];
            end
            used_count--;
         end
      end
      o.blocks_in_use = COUNT_W'(used_count);
      return o;
   endfunction

   // Mostly small allocations and frees of live blocks; the rest is noise
   function automatic ffba_pkg::req_type random_request();
      ffba_pkg::req_type r;
      int                roll;
      int                pick;
      r.func         = ffba_pkg::FUNC_ALLOC;
      r.alloc_size   = SIZE_W'($urandom_range(2047, 0));
      r.block_offset = OFFSET_W'($urandom_range(1023, 0));
      roll = $urandom_range(99, 0);
      pick = $urandom_range(99, 0);
      if (roll < 55) begin
         if (pick < 85) r.alloc_size = SIZE_W'($urandom_range(96, 1));
         else if (pick < 96) r.alloc_size = SIZE_W'($urandom_range(BUFFER_BYTES, 1));
      end else begin
         r.func = ffba_pkg::FUNC_FREE;
         if (used_count != 0 && pick < 80) begin
            r.block_offset = used_start[$urandom_range(used_count - 1, 0)];
            // hit the inside of a block now and then
            if (pick >= 70) r.block_offset = r.block_offset + 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void queue_alloc(int size);
      ffba_pkg::req_type r;
      r = '0;
      r.func = ffba_pkg::FUNC_ALLOC;
      r.alloc_size = SIZE_W'(size);
      request_backlog.push_back(r);
   endfunction

   function automatic void queue_free(int offset);
      ffba_pkg::req_type r;
      r = '0;
      r.func = ffba_pkg::FUNC_FREE;
      r.block_offset = OFFSET_W'(offset);
      request_backlog.push_back(r);
   endfunction

   // Hold until every request is taken and every reply has come back
   task automatic drain_requests();
      while (request_backlog.size() != 0 || start) @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
   endtask

   // Driver: score the beat taken at this edge, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_replies.push_back(apply_request(req_data));
         if (!start || !busy) begin
            if (request_backlog.size() != 0 &&
                $urandom_range(99, 0) >= sender_idle_pct) begin
               req_data <= request_backlog.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest expected reply
   always @(posedge clock) begin : result_check
      ffba_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_replies.size() == 0) begin
            $error("result beat with no request outstanding: offset %0d status %0d",
                   rsp_data.result_offset, rsp_data.status);
            failures++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.result_offset !== want.result_offset) begin
               $error("result_offset: expected %0d, got %0d",
                      want.result_offset, rsp_data.result_offset);
               failures++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.blocks_in_use !== want.blocks_in_use) begin
               $error("blocks_in_use: expected %0d, got %0d",
                      want.blocks_in_use, rsp_data.blocks_in_use);
               failures++;
            end
         end
      end
   end

   // Watchdog: give up after a long stretch with no beat moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int phase;
      int n;

      // Directed: empty table, bad sizes, exact fit, inside offset, then fill the table
      queue_free(0);
      queue_alloc(0);
      queue_alloc(2047);
      queue_alloc(BUFFER_BYTES + 1);
      queue_alloc(BUFFER_BYTES);
      queue_alloc(1);
      queue_free(1023);
      queue_free(0);
      for (n = 0; n < MAX_BLOCKS; n++) queue_alloc(BUFFER_BYTES / MAX_BLOCKS);
      queue_alloc(1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      drain_requests();

      // Random phases, each drained before the next one starts
      for (phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            @(negedge clock);
            while (request_backlog.size() >= 2) @(negedge clock);
            request_backlog.push_back(random_request());
         end
         drain_requests();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
